// ----- hdl/wcps_pkg.sv -----
`default_nettype none
package wcps_pkg;

  // Word mask bit positions
  localparam int WORD_BITS = 13;
  localparam logic [WORD_BITS-1:0] W_IT         = 13'h0001;
  localparam logic [WORD_BITS-1:0] W_IS         = 13'h0002;
  localparam logic [WORD_BITS-1:0] W_OCLOCK     = 13'h0004;
  localparam logic [WORD_BITS-1:0] W_PAST       = 13'h0008;
  localparam logic [WORD_BITS-1:0] W_TO         = 13'h0010;
  localparam logic [WORD_BITS-1:0] W_MINUTES    = 13'h0020;
  localparam logic [WORD_BITS-1:0] W_HALF       = 13'h0040;
  localparam logic [WORD_BITS-1:0] W_FIVE       = 13'h0080;
  localparam logic [WORD_BITS-1:0] W_TEN        = 13'h0100;
  localparam logic [WORD_BITS-1:0] W_FIFTEEN    = 13'h0200;
  localparam logic [WORD_BITS-1:0] W_TWENTY     = 13'h0400;
  localparam logic [WORD_BITS-1:0] W_TWENTYFIVE = 13'h0800;
  localparam logic [WORD_BITS-1:0] W_THIRTY     = 13'h1000;

  // Language codes
  localparam logic [1:0] LANG_ENGLISH = 2'd0;
  localparam logic [1:0] LANG_GERMAN  = 2'd1;
  localparam logic [1:0] LANG_SWISS   = 2'd2;

  // Configuration register indexes
  localparam logic REG_LANGUAGE  = 1'b0;
  localparam logic REG_HOUR_ZERO = 1'b1;

  // Five-minute band where the hour word advances
  localparam logic [3:0] BAND_ADV_EN = 4'd7;
  localparam logic [3:0] BAND_ADV_DE = 4'd5;
  localparam logic [3:0] BAND_LAST   = 4'd11;

  typedef struct packed {
    logic [1:0] language;
    logic       hour_zero_present;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic [3:0] hour_now;
    logic [3:0] hour_adv;
    logic [3:0] band;
    logic [2:0] dots;
  } qent_t;

  // Hour 0..32 to 12-hour form, 0 shown as 12
  function automatic logic [3:0] hour12(input logic [5:0] h);
    logic [5:0] r;
    if (h >= 6'd24) begin
      r = h - 6'd24;
    end else if (h >= 6'd12) begin
      r = h - 6'd12;
    end else begin
      r = h;
    end
    return (r == 6'd0) ? 4'd12 : r[3:0];
  endfunction

  // minute / 5 for minute 0..63, by reciprocal multiply (13/64)
  function automatic logic [3:0] band_of(input logic [5:0] m);
    logic [11:0] prod;
    prod = {6'd0, m} * 12'd13;
    return prod[9:6];
  endfunction

  // Band minute word, mirrored after the half hour
  function automatic logic [WORD_BITS-1:0] band_word(input logic [3:0] b);
    logic [WORD_BITS-1:0] w;
    case (b)
      4'd0:  w = W_OCLOCK;
      4'd1:  w = W_FIVE;
      4'd2:  w = W_TEN;
      4'd3:  w = W_FIFTEEN;
      4'd4:  w = W_TWENTY;
      4'd5:  w = W_TWENTYFIVE;
      4'd6:  w = W_THIRTY;
      4'd7:  w = W_TWENTYFIVE;
      4'd8:  w = W_TWENTY;
      4'd9:  w = W_FIFTEEN;
      4'd10: w = W_TEN;
      default: w = W_FIVE;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/wcps_front.sv -----
`default_nettype none
module wcps_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                time_valid,
  input  wire logic [4:0]          hour_of_day,
  input  wire logic [5:0]          minute_of_hour,
  output wcps_pkg::qent_t          q_data,
  output logic                     q_push
);
  import wcps_pkg::*;

  logic [4:0] last_hour;
  logic [5:0] last_minute;
  logic       last_seen;
  logic       is_new;
  logic [3:0] band_raw;
  logic [5:0] five_mult;

  // Drop invalid samples and repeats of the time already shown
  assign is_new = time_valid &&
                  (!last_seen || hour_of_day != last_hour || minute_of_hour != last_minute);
  assign q_push = accept && is_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_hour   <= '0;
      last_minute <= '0;
      last_seen   <= 1'b0;
    end else if (q_push) begin
      last_hour   <= hour_of_day;
      last_minute <= minute_of_hour;
      last_seen   <= 1'b1;
    end
  end

  // Classify: hour words, five-minute band and remainder
  assign band_raw  = band_of(minute_of_hour);
  assign five_mult = {band_raw, 2'b00} + {2'b00, band_raw};

  always_comb begin
    q_data.hour_now = hour12({1'b0, hour_of_day});
    q_data.hour_adv = hour12({1'b0, hour_of_day} + 6'd1);
    q_data.band     = (band_raw > BAND_LAST) ? BAND_LAST : band_raw;
    q_data.dots     = 3'(minute_of_hour - five_mult);
  end

endmodule
`default_nettype wire

// ----- hdl/wcps_queue.sv -----
`default_nettype none
module wcps_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wcps_pkg::qent_t          push_data,
  input  wire logic                pop,
  output wcps_pkg::qent_t          pop_data,
  output logic                     full,
  output logic                     empty
);
  import wcps_pkg::*;

  qent_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  // Two-entry ring between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/wcps_back.sv -----
`default_nettype none
module wcps_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wcps_pkg::cfg_t           cfg,
  input  wcps_pkg::qent_t          q_data,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic [12:0]              word_mask,
  output logic [3:0]               hour_num,
  output logic [2:0]               dot_count
);
  import wcps_pkg::*;

  logic                 out_valid;
  logic [WORD_BITS-1:0] mask_next;
  logic [3:0]           hour_next;
  logic [2:0]           dots_next;
  logic [3:0]           b;

  assign b     = q_data.band;
  assign empty = !out_valid;
  assign q_pop = !q_empty && (!out_valid || pop);

  // Phrase rules per language
  always_comb begin
    mask_next = W_IT | W_IS | band_word(b);
    hour_next = q_data.hour_now;
    dots_next = 3'd0;
    case (cfg.language)
      LANG_GERMAN: begin
        case (b)
          4'd0:         mask_next = mask_next | W_OCLOCK;
          4'd1, 4'd2:   mask_next = mask_next | W_PAST | W_MINUTES;
          4'd3:         mask_next = mask_next | W_PAST;
          4'd4:         mask_next = mask_next | W_PAST | W_MINUTES;
          4'd5:         mask_next = mask_next | W_FIVE | W_TO;
          4'd6:         mask_next = mask_next | W_HALF;
          4'd7:         mask_next = mask_next | W_FIVE | W_PAST;
          4'd8:         mask_next = mask_next | W_TO | W_MINUTES;
          4'd9:         mask_next = mask_next | W_TO;
          default:      mask_next = mask_next | W_TO | W_MINUTES;
        endcase
        if (b >= BAND_ADV_DE) begin
          hour_next = q_data.hour_adv;
        end
        // Separate word for one o'clock sharp
        if (q_data.hour_now == 4'd1 && b == 4'd0 && cfg.hour_zero_present) begin
          hour_next = 4'd0;
        end
      end
      LANG_SWISS: begin
        case (b)
          4'd0:                   mask_next = mask_next | W_OCLOCK;
          4'd1, 4'd2, 4'd3, 4'd4: mask_next = mask_next | W_PAST;
          4'd5:                   mask_next = mask_next | W_TO | W_FIVE;
          4'd6:                   mask_next = mask_next;
          4'd7:                   mask_next = mask_next | W_PAST | W_FIVE;
          default:                mask_next = mask_next | W_TO | W_MINUTES;
        endcase
        if (b >= BAND_ADV_DE) begin
          hour_next = q_data.hour_adv;
        end
        dots_next = q_data.dots;
      end
      default: begin
        // English, also for the unused code
        if (b == 4'd0) begin
          mask_next = mask_next | W_OCLOCK;
        end else if (b < BAND_ADV_EN) begin
          mask_next = mask_next | W_PAST | W_MINUTES;
        end else begin
          mask_next = mask_next | W_TO | W_MINUTES;
          hour_next = q_data.hour_adv;
        end
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_mask <= mask_next;
      hour_num  <= hour_next;
      dot_count <= dots_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/word_clock_phrase_select_unit.sv -----
// An accepted time is written into the queue and from there into the output register,
// which loads when the output is empty or being popped; it is then popped from the result ports.
// Throughput: one item per cycle while pop is held high; the output register reloads in the cycle it is popped.
// Samples that are invalid or repeat the last time shown give no result.
// Reset (rst, synchronous): queue and output emptied, nothing shown yet,
// language English, no one-o'clock word.
`default_nettype none
module word_clock_phrase_select_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        time_valid,
  input  wire logic [4:0]  hour_of_day,
  input  wire logic [5:0]  minute_of_hour,
  output logic             empty,
  input  wire logic        pop,
  output logic [12:0]      word_mask,
  output logic [3:0]       hour_num,
  output logic [2:0]       dot_count,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);
  import wcps_pkg::*;

  cfg_t  cfg;
  qent_t fq_data;
  qent_t qb_data;
  logic  fq_push;
  logic  qb_pop;
  logic  q_empty;
  logic  accept;

  assign accept = push && !full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.language          <= LANG_ENGLISH;
      cfg.hour_zero_present <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LANGUAGE:  cfg.language          <= cfg_data;
        REG_HOUR_ZERO: cfg.hour_zero_present <= cfg_data[0];
        default:       cfg.language          <= cfg.language;
      endcase
    end
  end

  wcps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .time_valid     (time_valid),
    .hour_of_day    (hour_of_day),
    .minute_of_hour (minute_of_hour),
    .q_data         (fq_data),
    .q_push         (fq_push)
  );

  wcps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_push),
    .push_data (fq_data),
    .pop       (qb_pop),
    .pop_data  (qb_data),
    .full      (full),
    .empty     (q_empty)
  );

  wcps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_data      (qb_data),
    .q_empty     (q_empty),
    .q_pop       (qb_pop),
    .pop         (pop),
    .empty       (empty),
    .word_mask   (word_mask),
    .hour_num    (hour_num),
    .dot_count   (dot_count)
  );

endmodule
`default_nettype wire

// ----- tb/word_clock_phrase_select_unit_tb.sv -----
`timescale 1ns / 100ps
module word_clock_phrase_select_unit_tb;
  import wcps_pkg::*;

  // Code 3 has no phrasing of its own and falls back to English
  localparam logic [1:0] LANG_SPARE = 2'd3;

  typedef struct packed {
    logic [12:0] mask;
    logic [3:0]  hour;
    logic [2:0]  dots;
  } phrase_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        time_valid;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic        empty;
  logic        pop;
  logic [12:0] word_mask;
  logic [3:0]  hour_num;
  logic [2:0]  dot_count;
  logic        cfg_write;
  logic        cfg_index;
  logic [1:0]  cfg_data;

  word_clock_phrase_select_unit u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .time_valid(time_valid),
    .hour_of_day(hour_of_day),
    .minute_of_hour(minute_of_hour),
    .empty(empty),
    .pop(pop),
    .word_mask(word_mask),
    .hour_num(hour_num),
    .dot_count(dot_count),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor copy of registers and display state
  logic [1:0] lang_cfg;
  logic       hour_zero_cfg;
  logic       shown_valid;
  logic [4:0] shown_hour;
  logic [5:0] shown_minute;

  phrase_t phrase_q[$];
  int      mismatch_count;
  int      items_taken;
  int      phrases_checked;
  bit      idle_on;
  int      pop_hold;

  // Running wall clock used for well-formed random sequences
  int unsigned tick_h;
  int unsigned tick_m;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hour in 12-hour dial form, 0 shown as 12
  function automatic logic [3:0] dial_hour(input int unsigned h);
    int unsigned r;
    r = h % 12;
    return (r == 0) ? 4'd12 : r[3:0];
  endfunction

  // Expected phrase for one accepted item, if any
  function automatic void predict_phrase(input logic v, input logic [4:0] h,
                                         input logic [5:0] m);
    phrase_t     e;
    int unsigned hi;
    int unsigned mi;
    int unsigned b;
    if (!v) return;
    if (shown_valid && h == shown_hour && m == shown_minute) return;
    shown_valid = 1'b1;
    shown_hour = h;
    shown_minute = m;
    hi = h;
    mi = m;
    e.mask = W_IT | W_IS;
    e.hour = dial_hour(hi);
    e.dots = 3'd0;
    case (lang_cfg)
      LANG_GERMAN: begin
        if (mi < 5)       e.mask |= W_OCLOCK;
        else if (mi < 15) e.mask |= W_PAST | W_MINUTES;
        else if (mi < 20) e.mask |= W_PAST;
        else if (mi < 25) e.mask |= W_PAST | W_MINUTES;
        else if (mi < 30) e.mask |= W_FIVE | W_TO;
        else if (mi < 35) e.mask |= W_HALF;
        else if (mi < 40) e.mask |= W_FIVE | W_PAST;
        else if (mi < 45) e.mask |= W_TO | W_MINUTES;
        else if (mi < 50) e.mask |= W_TO;
        else              e.mask |= W_TO | W_MINUTES;
        if (mi >= 25) e.hour = dial_hour(hi + 1);
        // one o'clock sharp has its own word on some layouts
        if (e.hour == 4'd1 && mi < 5 && hour_zero_cfg) e.hour = 4'd0;
      end
      LANG_SWISS: begin
        if (mi < 5)       e.mask |= W_OCLOCK;
        else if (mi < 25) e.mask |= W_PAST;
        else if (mi < 30) e.mask |= W_TO | W_FIVE;
        else if (mi < 35) e.mask |= '0;
        else if (mi < 40) e.mask |= W_PAST | W_FIVE;
        else              e.mask |= W_TO | W_MINUTES;
        if (mi >= 25) e.hour = dial_hour(hi + 1);
        e.dots = (mi % 5 > 4) ? 3'd4 : 3'(mi % 5);
      end
      default: begin
        if (mi < 5) begin
          e.mask |= W_OCLOCK;
        end else if (mi < 35) begin
          e.mask |= W_PAST | W_MINUTES;
        end else begin
          e.mask |= W_TO | W_MINUTES;
          e.hour = dial_hour(hi + 1);
        end
      end
    endcase
    // five-minute band word, mirrored after the half hour, clamped past :59
    b = mi / 5;
    if (b > 11) b = 11;
    case (b)
      0:       e.mask |= W_OCLOCK;
      1, 11:   e.mask |= W_FIVE;
      2, 10:   e.mask |= W_TEN;
      3, 9:    e.mask |= W_FIFTEEN;
      4, 8:    e.mask |= W_TWENTY;
      5, 7:    e.mask |= W_TWENTYFIVE;
      default: e.mask |= W_THIRTY;
    endcase
    phrase_q.push_back(e);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk) begin : check_result
    phrase_t want;
    if (!rst && pop && !empty) begin
      phrases_checked++;
      if (phrase_q.size() == 0) begin
        note_mismatch($sformatf("unexpected phrase mask=%h hour=%0d dots=%0d",
                                word_mask, hour_num, dot_count));
      end else begin
        want = phrase_q.pop_front();
        if (word_mask !== want.mask)
          note_mismatch($sformatf("word_mask %h, want %h", word_mask, want.mask));
        if (hour_num !== want.hour)
          note_mismatch($sformatf("hour_num %0d, want %0d", hour_num, want.hour));
        if (dot_count !== want.dots)
          note_mismatch($sformatf("dot_count %0d, want %0d", dot_count, want.dots));
      end
    end
  end

  // Receiver side: pop with random stall bursts
  initial begin
    pop = 1'b0;
    pop_hold = 0;
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop = 1'b0;
        pop_hold--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        pop_hold = $urandom_range(1, 17) - 1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Send one item; entered and left at a falling edge, push left high
  task automatic send_time(input logic v, input logic [4:0] h, input logic [5:0] m);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    push = 1'b1;
    time_valid = v;
    hour_of_day = h;
    minute_of_hour = m;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
    end
    predict_phrase(v, h, m);
    items_taken++;
    @(negedge clk);
  endtask

  // Stop sending, wait for all phrases plus pipeline latency
  task automatic settle();
    push = 1'b0;
    while (phrase_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Register write; block must be idle
  task automatic write_reg(input logic idx, input logic [1:0] d);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_LANGUAGE) lang_cfg = d;
    else hour_zero_cfg = d[0];
  endtask

  // Defaults after reset: first sample always shows, repeats and invalid do not
  task automatic test_first_sample();
    send_time(1'b1, 5'd0, 6'd0);
    send_time(1'b1, 5'd0, 6'd0);
    send_time(1'b0, 5'd5, 6'd30);
    send_time(1'b1, 5'd0, 6'd0);
    settle();
  endtask

  // English bands, hour advance at :35, out-of-range hour and minute
  task automatic test_english();
    write_reg(REG_LANGUAGE, LANG_ENGLISH);
    write_reg(REG_HOUR_ZERO, 2'b00);
    send_time(1'b1, 5'd23, 6'd35);
    send_time(1'b1, 5'd11, 6'd59);
    send_time(1'b1, 5'd31, 6'd63);
    send_time(1'b1, 5'd12, 6'd4);
    send_time(1'b1, 5'd16, 6'd34);
    settle();
  endtask

  // German with the one-o'clock word, advance at :25
  task automatic test_german();
    write_reg(REG_LANGUAGE, LANG_GERMAN);
    write_reg(REG_HOUR_ZERO, 2'b11);
    send_time(1'b1, 5'd1, 6'd0);
    send_time(1'b1, 5'd13, 6'd4);
    send_time(1'b1, 5'd0, 6'd25);
    send_time(1'b1, 5'd12, 6'd30);
    send_time(1'b1, 5'd1, 6'd5);
    send_time(1'b1, 5'd9, 6'd45);
    send_time(1'b1, 5'd20, 6'd60);
    settle();
  endtask

  // Swiss phrasing and minute dots
  task automatic test_swiss();
    write_reg(REG_LANGUAGE, LANG_SWISS);
    send_time(1'b1, 5'd1, 6'd0);
    send_time(1'b1, 5'd7, 6'd24);
    send_time(1'b1, 5'd7, 6'd29);
    send_time(1'b1, 5'd7, 6'd33);
    send_time(1'b1, 5'd7, 6'd39);
    send_time(1'b1, 5'd23, 6'd63);
    settle();
  endtask

  // Unused language code
  task automatic test_spare_language();
    write_reg(REG_LANGUAGE, LANG_SPARE);
    write_reg(REG_HOUR_ZERO, 2'b10);
    send_time(1'b1, 5'd0, 6'd37);
    send_time(1'b1, 5'd29, 6'd7);
    settle();
  endtask

  // Mostly a ticking clock, with jumps, repeats and invalid noise
  task automatic random_items(input int count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        tick_m += ($urandom_range(0, 3) == 0) ? $urandom_range(2, 7) : 1;
        if (tick_m > 59) begin
          tick_m -= 60;
          tick_h = (tick_h + 1) % 24;
        end
        send_time(1'b1, 5'(tick_h), 6'(tick_m));
      end else if (pick < 78) begin
        send_time(1'b1, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
      end else if (pick < 88) begin
        tick_h = $urandom_range(0, 23);
        tick_m = $urandom_range(0, 59);
        send_time(1'b1, 5'(tick_h), 6'(tick_m));
      end else if (pick < 94) begin
        send_time(1'b1, shown_hour, shown_minute);
      end else begin
        send_time(1'b0, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
      end
    end
  endtask

  // Random phases across settings; the last one runs without idling
  task automatic test_random_phases();
    logic [1:0] langs [6];
    logic       zeros [6];
    langs = '{LANG_ENGLISH, LANG_GERMAN, LANG_GERMAN, LANG_SWISS, LANG_SPARE, LANG_GERMAN};
    zeros = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    tick_h = 0;
    tick_m = 0;
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_LANGUAGE, langs[p]);
      write_reg(REG_HOUR_ZERO, {1'($urandom_range(0, 1)), zeros[p]});
      if (p == 5) idle_on = 1'b0;
      random_items(125);
      settle();
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    time_valid = 1'b0;
    hour_of_day = '0;
    minute_of_hour = '0;
    cfg_write = 1'b0;
    cfg_index = REG_LANGUAGE;
    cfg_data = '0;
    lang_cfg = LANG_ENGLISH;
    hour_zero_cfg = 1'b0;
    shown_valid = 1'b0;
    shown_hour = '0;
    shown_minute = '0;
    mismatch_count = 0;
    items_taken = 0;
    phrases_checked = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_first_sample();
    test_english();
    test_german();
    test_swiss();
    test_spare_language();
    test_random_phases();

    $display("Sent %0d time samples over English, German, Swiss and spare language codes,",
             items_taken);
    $display("with and without the one-o'clock word; %0d phrases checked.",
             phrases_checked);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("Run limit reached with %0d phrases outstanding", phrase_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
